@@ hdl/itrf_pkg.sv @@
// ----------------------------------------------------------------------------
// itrf_pkg
// Shared types and constants of the I2C target register file.
// ----------------------------------------------------------------------------
package itrf_pkg;

  localparam int unsigned RxDepthDefault     = 32;
  localparam int unsigned NonceBytesDefault  = 16;
  localparam int unsigned ConfigBytesDefault = 16;
  localparam int unsigned TxDepthDefault     = 16;

  localparam logic [7:0] StatusRegReset  = 8'd0;
  localparam logic [7:0] NonceRegReset   = 8'd1;
  localparam logic [7:0] ConfigRegReset  = 8'd2;
  localparam logic [7:0] CommandRegReset = 8'd3;

  localparam logic [7:0] PadByte = 8'h00;

  typedef enum logic [3:0] {
    OP_BUS_ERROR   = 4'd0,
    OP_ADDR_READ   = 4'd1,
    OP_ADDR_WRITE  = 4'd2,
    OP_STOP        = 4'd3,
    OP_TX_SLOT     = 4'd4,
    OP_RX_BYTE     = 4'd5,
    OP_LOAD_NONCE  = 4'd6,
    OP_LOAD_CONFIG = 4'd7,
    OP_READ_RX     = 4'd8,
    OP_READ_ARMED  = 4'd9,
    OP_CLEAR_FLAGS = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    CFG_STATUS  = 2'd0,
    CFG_NONCE   = 2'd1,
    CFG_CONFIG  = 2'd2,
    CFG_COMMAND = 2'd3
  } cfg_e;

  typedef struct packed {
    logic cmd;
    logic cfg;
    logic armed;
    logic consumed;
  } flags_t;

  typedef struct packed {
    logic       bus_action;
    logic [7:0] tx_byte;
    logic [7:0] host_byte;
    logic       use_rx_buffer;
    flags_t     flags;
    logic [5:0] received_length;
    logic [7:0] register_pointer;
  } result_t;

endpackage

@@ hdl/itrf_rx_buffer.sv @@
// ----------------------------------------------------------------------------
// itrf_rx_buffer
// Receive byte buffer: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module itrf_rx_buffer #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/i2c_target_register_file.sv @@
// ----------------------------------------------------------------------------
// i2c_target_register_file
// Transaction layer of an I2C target with a sticky register pointer.
// ----------------------------------------------------------------------------
// Each request on the input channel is one bus event or host operation, and
// it produces exactly one result on the output channel. The block state is
// updated in the cycle the request is accepted; the receive buffer answers
// host reads from a synchronous memory whose registered read data joins the
// result as it moves from the first result stage to the output register.
// One request is taken every cycle while the output is not stalled. Two
// result stages sit between the channels, so a new request is still taken
// while a finished result waits; when the receiver stalls for longer, the
// input stalls after one more request. Configuration writes take effect at
// once; the user must make them only while the block is idle, and the block
// itself does not enforce this. Reset clears the pointer, counters, flags and
// the nonce and config stores at once; the receive buffer and transmit copy
// are not reset, and the transmit copy is only read where it was written.
// ----------------------------------------------------------------------------
module i2c_target_register_file #(
  parameter int unsigned RX_DEPTH     = itrf_pkg::RxDepthDefault,
  parameter int unsigned NONCE_BYTES  = itrf_pkg::NonceBytesDefault,
  parameter int unsigned CONFIG_BYTES = itrf_pkg::ConfigBytesDefault,
  parameter int unsigned TX_DEPTH     = itrf_pkg::TxDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] op_i,
  input  logic [7:0] byte_in_i,
  input  logic       master_nack_i,
  input  logic [4:0] byte_index_i,
  input  logic [7:0] status_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       bus_action_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] host_byte_o,
  output logic       command_pending_o,
  output logic       config_pending_o,
  output logic [5:0] received_length_o,
  output logic       nonce_armed_o,
  output logic       nonce_consumed_o,
  output logic [7:0] register_pointer_o
);

  import itrf_pkg::*;

  localparam int unsigned AW   = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(RX_DEPTH + 2);
  localparam int unsigned TLW  = $clog2(TX_DEPTH + 1);
  localparam int unsigned TPW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned NIW  = (NONCE_BYTES > 1) ? $clog2(NONCE_BYTES) : 1;
  localparam int unsigned CIW  = (CONFIG_BYTES > 1) ? $clog2(CONFIG_BYTES) : 1;
  localparam int unsigned TxNonceN  = (NONCE_BYTES < TX_DEPTH) ? NONCE_BYTES : TX_DEPTH;
  localparam int unsigned TxConfigN = (CONFIG_BYTES < TX_DEPTH) ? CONFIG_BYTES : TX_DEPTH;

  logic [7:0] nonce_reg_q, config_reg_q, command_reg_q;

  logic [7:0]     ptr_q, ptr_d;
  logic           expect_q, expect_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  posted_q, posted_d;
  logic [TLW-1:0] txlen_q, txlen_d;
  logic [TLW-1:0] txpos_q, txpos_d;
  flags_t         flags_q, flags_d;

  logic [7:0] next_nonce_q [NONCE_BYTES];
  logic [7:0] next_nonce_d [NONCE_BYTES];
  logic [7:0] armed_q      [NONCE_BYTES];
  logic [7:0] armed_d      [NONCE_BYTES];
  logic [7:0] config_q     [CONFIG_BYTES];
  logic [7:0] config_d     [CONFIG_BYTES];
  logic [7:0] tx_store_q   [TX_DEPTH];
  logic [7:0] tx_store_d   [TX_DEPTH];

  logic       in_accept;
  logic       s1_adv;
  logic       s1_valid_q;
  result_t    s1_q, s1_d;
  logic       out_valid_q;
  result_t    out_q, out_d;

  logic          rx_we;
  logic [AW-1:0] rx_rd_addr;
  logic [7:0]    rx_rd_data;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign rx_rd_addr = AW'(byte_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_reg_q   <= NonceRegReset;
      config_reg_q  <= ConfigRegReset;
      command_reg_q <= CommandRegReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NONCE:   nonce_reg_q   <= cfg_wdata_i;
        CFG_CONFIG:  config_reg_q  <= cfg_wdata_i;
        CFG_COMMAND: command_reg_q <= cfg_wdata_i;
        default: begin
          // A write to the status register number has no effect; the pointer resets to StatusRegReset.
        end
      endcase
    end
  end

  always_comb begin
    ptr_d        = ptr_q;
    expect_d     = expect_q;
    cnt_d        = cnt_q;
    posted_d     = posted_q;
    txlen_d      = txlen_q;
    txpos_d      = txpos_q;
    flags_d      = flags_q;
    next_nonce_d = next_nonce_q;
    armed_d      = armed_q;
    config_d     = config_q;
    tx_store_d   = tx_store_q;
    rx_we        = 1'b0;
    s1_d         = '0;
    s1_d.tx_byte   = PadByte;
    s1_d.host_byte = PadByte;
    if (in_accept) begin
      case (op_i)
        OP_BUS_ERROR: begin
          expect_d        = 1'b0;
          s1_d.bus_action = 1'b1;
        end
        OP_ADDR_READ: begin
          if (ptr_q == nonce_reg_q) begin
            armed_d          = next_nonce_q;
            flags_d.armed    = 1'b1;
            flags_d.consumed = 1'b1;
            for (int i = 0; i < TxNonceN; i++) begin
              tx_store_d[i] = next_nonce_q[i];
            end
            txlen_d = TLW'(TxNonceN);
          end else if (ptr_q == config_reg_q) begin
            for (int i = 0; i < TxConfigN; i++) begin
              tx_store_d[i] = config_q[i];
            end
            txlen_d = TLW'(TxConfigN);
          end else begin
            tx_store_d[0] = status_byte_i;
            txlen_d       = TLW'(1);
          end
          txpos_d = '0;
        end
        OP_ADDR_WRITE: begin
          expect_d = 1'b0;
          cnt_d    = '0;
        end
        OP_STOP: begin
          if (cnt_q != '0) begin
            if (ptr_q == command_reg_q) begin
              posted_d    = cnt_q;
              flags_d.cmd = 1'b1;
            end else if (ptr_q == config_reg_q) begin
              posted_d    = cnt_q;
              flags_d.cfg = 1'b1;
            end
          end
          s1_d.bus_action = 1'b1;
        end
        OP_TX_SLOT: begin
          if (txpos_q != '0 && master_nack_i) begin
            s1_d.bus_action = 1'b1;
          end else begin
            if (txpos_q < txlen_q && txpos_q < TLW'(TX_DEPTH)) begin
              s1_d.tx_byte = tx_store_q[txpos_q[TPW-1:0]];
            end
            if (txpos_q < TLW'(TX_DEPTH)) begin
              txpos_d = txpos_q + 1'b1;
            end
          end
        end
        OP_RX_BYTE: begin
          if (!expect_q) begin
            ptr_d    = byte_in_i;
            expect_d = 1'b1;
            cnt_d    = '0;
          end else begin
            if ((ptr_q == command_reg_q || ptr_q == config_reg_q)
                && cnt_q < CW'(RX_DEPTH)) begin
              rx_we = 1'b1;
            end
            if (cnt_q <= CW'(RX_DEPTH)) begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        OP_LOAD_NONCE: begin
          if (32'(byte_index_i) < NONCE_BYTES) begin
            next_nonce_d[NIW'(byte_index_i)] = byte_in_i;
          end
        end
        OP_LOAD_CONFIG: begin
          if (32'(byte_index_i) < CONFIG_BYTES) begin
            config_d[CIW'(byte_index_i)] = byte_in_i;
          end
        end
        OP_READ_RX: begin
          if (32'(byte_index_i) < RX_DEPTH) begin
            s1_d.use_rx_buffer = 1'b1;
          end
        end
        OP_READ_ARMED: begin
          if (32'(byte_index_i) < NONCE_BYTES) begin
            s1_d.host_byte = armed_q[NIW'(byte_index_i)];
          end
        end
        OP_CLEAR_FLAGS: begin
          flags_d = '0;
        end
        default: begin
        end
      endcase
    end
    s1_d.flags            = flags_d;
    s1_d.received_length  = 6'(posted_d);
    s1_d.register_pointer = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= StatusRegReset;
      expect_q   <= 1'b0;
      cnt_q      <= '0;
      posted_q   <= '0;
      txlen_q    <= '0;
      txpos_q    <= '0;
      flags_q    <= '0;
      for (int i = 0; i < NONCE_BYTES; i++) begin
        next_nonce_q[i] <= '0;
        armed_q[i]      <= '0;
      end
      for (int i = 0; i < CONFIG_BYTES; i++) begin
        config_q[i] <= '0;
      end
    end else begin
      ptr_q        <= ptr_d;
      expect_q     <= expect_d;
      cnt_q        <= cnt_d;
      posted_q     <= posted_d;
      txlen_q      <= txlen_d;
      txpos_q      <= txpos_d;
      flags_q      <= flags_d;
      next_nonce_q <= next_nonce_d;
      armed_q      <= armed_d;
      config_q     <= config_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_store_q <= tx_store_d;
  end

  itrf_rx_buffer #(
    .DEPTH (RX_DEPTH),
    .AW    (AW)
  ) u_rx_buffer (
    .clk_i     (clk_i),
    .wr_en_i   (rx_we),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (byte_in_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (rx_rd_addr),
    .rd_data_o (rx_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_comb begin
    out_d = s1_q;
    if (s1_q.use_rx_buffer) begin
      out_d.host_byte = rx_rd_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign bus_action_o       = out_q.bus_action;
  assign tx_byte_o          = out_q.tx_byte;
  assign host_byte_o        = out_q.host_byte;
  assign command_pending_o  = out_q.flags.cmd;
  assign config_pending_o   = out_q.flags.cfg;
  assign received_length_o  = out_q.received_length;
  assign nonce_armed_o      = out_q.flags.armed;
  assign nonce_consumed_o   = out_q.flags.consumed;
  assign register_pointer_o = out_q.register_pointer;

`ifndef SYNTHESIS
  a_txpos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    txpos_q <= TLW'(TX_DEPTH))
    else $error("transmit position beyond transmit depth");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RX_DEPTH + 1))
    else $error("receive count beyond saturation value");

  a_nonce_arm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_i == OP_ADDR_READ && ptr_q == nonce_reg_q
    |=> s1_valid_q && s1_q.flags.armed && s1_q.flags.consumed)
    else $error("nonce read did not arm the nonce flags");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("stalled result stage lost its contents");
`endif

endmodule

@@ tb/sv/tb_i2c_target_register_file.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_target_register_file
// Self-checking testbench for the I2C target register file.
// ----------------------------------------------------------------------------
// A queue of bus events and host operations feeds a valid/ready driver, and a
// monitor takes the results under random back-pressure. Each request that the
// block accepts runs through a behavioral copy of the transaction layer, and
// the reply it predicts is compared field by field with the next result. A
// short directed sequence comes first, then write and read
// transactions, host operations and noise under several register maps.
// ----------------------------------------------------------------------------
module tb_i2c_target_register_file;
  import itrf_pkg::*;

  localparam int unsigned RxDepth     = RxDepthDefault;
  localparam int unsigned NonceBytes  = NonceBytesDefault;
  localparam int unsigned ConfigBytes = ConfigBytesDefault;
  localparam int unsigned TxDepth     = TxDepthDefault;
  localparam int unsigned NonceTxLen  = (NonceBytes > TxDepth) ? TxDepth : NonceBytes;
  localparam int unsigned ConfigTxLen = (ConfigBytes > TxDepth) ? TxDepth : ConfigBytes;
  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PrintLimit  = 100;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
    logic       nack;
    logic [4:0] index;
    logic [7:0] status;
  } bus_event_t;

  typedef struct packed {
    logic       bus_action;
    logic [7:0] tx_byte;
    logic [7:0] host_byte;
    logic       cmd_pending;
    logic       cfg_pending;
    logic [5:0] rx_length;
    logic       armed;
    logic       consumed;
    logic [7:0] pointer;
  } target_reply_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = '0;
  logic [7:0] cfg_wdata_i   = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [3:0] op_i          = '0;
  logic [7:0] byte_in_i     = '0;
  logic       master_nack_i = 1'b0;
  logic [4:0] byte_index_i  = '0;
  logic [7:0] status_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       bus_action_o;
  logic [7:0] tx_byte_o;
  logic [7:0] host_byte_o;
  logic       command_pending_o;
  logic       config_pending_o;
  logic [5:0] received_length_o;
  logic       nonce_armed_o;
  logic       nonce_consumed_o;
  logic [7:0] register_pointer_o;

  i2c_target_register_file u_top (.*);

  // Register map and transaction state as the block should hold them.
  logic [7:0] map_status  = StatusRegReset;
  logic [7:0] map_nonce   = NonceRegReset;
  logic [7:0] map_config  = ConfigRegReset;
  logic [7:0] map_command = CommandRegReset;

  logic [7:0] pointer_q   = StatusRegReset;
  logic       expect_data = 1'b0;
  logic [5:0] rx_count    = '0;
  logic [7:0] rx_mem      [RxDepth]     = '{default: '0};
  bit         rx_filled   [RxDepth]     = '{default: 1'b0};
  logic [7:0] tx_mem      [TxDepth]     = '{default: '0};
  logic [4:0] tx_len      = '0;
  logic [4:0] tx_pos      = '0;
  logic [7:0] nonce_next  [NonceBytes]  = '{default: '0};
  logic [7:0] nonce_held  [NonceBytes]  = '{default: '0};
  logic [7:0] cfg_blob    [ConfigBytes] = '{default: '0};
  flags_t     flags       = '0;
  logic [5:0] posted_len  = '0;

  bus_event_t    pending_events   [$];
  target_reply_t expected_replies [$];
  bus_event_t    held_event;

  int unsigned sent_count    = 0;
  int unsigned accepted_count = 0;
  int unsigned outstanding   = 0;
  int unsigned stim_items    = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  bit          gaps_on       = 1'b1;

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_pointer();
    case ($urandom_range(0, 4))
      0: return map_status;
      1: return map_nonce;
      2: return map_config;
      3: return map_command;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] seen);
    if (mismatches < PrintLimit) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $time, what, want, seen);
    end
    mismatches++;
  endtask

  // Advances the transaction state by one request and queues its reply.
  task automatic apply_bus_event(input bus_event_t ev);
    target_reply_t rep;
    int            i;
    rep = '0;
    case (ev.op)
      OP_BUS_ERROR: begin
        expect_data = 1'b0;
        rep.bus_action = 1'b1;
      end
      OP_ADDR_READ: begin
        if (pointer_q == map_nonce) begin
          for (i = 0; i < NonceBytes; i++) nonce_held[i] = nonce_next[i];
          flags.armed = 1'b1;
          flags.consumed = 1'b1;
          for (i = 0; i < NonceTxLen; i++) tx_mem[i] = nonce_held[i];
          tx_len = 5'(NonceTxLen);
        end else if (pointer_q == map_config) begin
          for (i = 0; i < ConfigTxLen; i++) tx_mem[i] = cfg_blob[i];
          tx_len = 5'(ConfigTxLen);
        end else begin
          tx_mem[0] = ev.status;
          tx_len = 5'd1;
        end
        tx_pos = '0;
      end
      OP_ADDR_WRITE: begin
        expect_data = 1'b0;
        rx_count = '0;
      end
      OP_STOP: begin
        if (rx_count >= 1) begin
          if (pointer_q == map_command) begin
            posted_len = rx_count;
            flags.cmd = 1'b1;
          end else if (pointer_q == map_config) begin
            posted_len = rx_count;
            flags.cfg = 1'b1;
          end
        end
        rep.bus_action = 1'b1;
      end
      OP_TX_SLOT: begin
        if (tx_pos != 0 && ev.nack) begin
          rep.bus_action = 1'b1;
        end else begin
          if (tx_pos < tx_len && tx_pos < TxDepth) rep.tx_byte = tx_mem[tx_pos[3:0]];
          if (tx_pos < TxDepth) tx_pos++;
        end
      end
      OP_RX_BYTE: begin
        if (!expect_data) begin
          pointer_q = ev.data;
          expect_data = 1'b1;
          rx_count = '0;
        end else begin
          if ((pointer_q == map_command || pointer_q == map_config)
              && rx_count < RxDepth) begin
            rx_mem[rx_count[4:0]] = ev.data;
            rx_filled[rx_count[4:0]] = 1'b1;
          end
          if (rx_count <= RxDepth) rx_count++;
        end
      end
      OP_LOAD_NONCE: begin
        if (ev.index < NonceBytes) nonce_next[ev.index[3:0]] = ev.data;
      end
      OP_LOAD_CONFIG: begin
        if (ev.index < ConfigBytes) cfg_blob[ev.index[3:0]] = ev.data;
      end
      OP_READ_RX: begin
        if (ev.index < RxDepth) rep.host_byte = rx_mem[ev.index];
      end
      OP_READ_ARMED: begin
        if (ev.index < NonceBytes) rep.host_byte = nonce_held[ev.index[3:0]];
      end
      OP_CLEAR_FLAGS: begin
        flags = '0;
      end
      default: begin
      end
    endcase
    rep.cmd_pending = flags.cmd;
    rep.cfg_pending = flags.cfg;
    rep.rx_length   = posted_len;
    rep.armed       = flags.armed;
    rep.consumed    = flags.consumed;
    rep.pointer     = pointer_q;
    expected_replies.push_back(rep);
    outstanding++;
  endtask

  // A host read of the receive buffer waits until the queue has drained, so
  // that it only targets entries that a bus write has filled; with none filled it becomes an armed read.
  task automatic send(input logic [3:0] op, input logic [7:0] data, input logic nack,
                      input logic [4:0] index, input logic [7:0] status);
    bus_event_t ev;
    int         i;
    int         start;
    logic [4:0] slot;
    ev.op = op;
    ev.data = data;
    ev.nack = nack;
    ev.index = index;
    ev.status = status;
    if (op == OP_READ_RX) begin
      wait (accepted_count == sent_count);
      @(negedge clk_i);
      if (!rx_filled[index]) begin
        ev.op = OP_READ_ARMED;
        start = $urandom_range(0, RxDepth - 1);
        for (i = 0; i < RxDepth; i++) begin
          slot = 5'((start + i) % RxDepth);
          if (rx_filled[slot]) begin
            ev.op = OP_READ_RX;
            ev.index = slot;
          end
        end
      end
    end
    pending_events.push_back(ev);
    sent_count++;
    if (ev.op <= OP_CLEAR_FLAGS) stim_items++;
  endtask

  task automatic send_random(input logic [3:0] op);
    send(op, 8'($urandom), 1'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    wait (accepted_count == sent_count && outstanding == 0);
    @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_e index, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    case (index)
      CFG_STATUS:  map_status = value;
      CFG_NONCE:   map_nonce = value;
      CFG_CONFIG:  map_config = value;
      CFG_COMMAND: map_command = value;
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_bus_event(held_event);
        accepted_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_events.size() > 0) begin
          held_event = pending_events.pop_front();
          op_i <= held_event.op;
          byte_in_i <= held_event.data;
          master_nack_i <= held_event.nack;
          byte_index_i <= held_event.index;
          status_byte_i <= held_event.status;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    target_reply_t got;
    target_reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.bus_action  = bus_action_o;
        got.tx_byte     = tx_byte_o;
        got.host_byte   = host_byte_o;
        got.cmd_pending = command_pending_o;
        got.cfg_pending = config_pending_o;
        got.rx_length   = received_length_o;
        got.armed       = nonce_armed_o;
        got.consumed    = nonce_consumed_o;
        got.pointer     = register_pointer_o;
        if (expected_replies.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, '0);
        end else begin
          want = expected_replies.pop_front();
          outstanding--;
          if (got.bus_action !== want.bus_action)
            report_mismatch("bus_action", want.bus_action, got.bus_action);
          if (got.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", want.tx_byte, got.tx_byte);
          if (got.host_byte !== want.host_byte)
            report_mismatch("host_byte", want.host_byte, got.host_byte);
          if (got.cmd_pending !== want.cmd_pending)
            report_mismatch("command_pending", want.cmd_pending, got.cmd_pending);
          if (got.cfg_pending !== want.cfg_pending)
            report_mismatch("config_pending", want.cfg_pending, got.cfg_pending);
          if (got.rx_length !== want.rx_length)
            report_mismatch("received_length", want.rx_length, got.rx_length);
          if (got.armed !== want.armed)
            report_mismatch("nonce_armed", want.armed, got.armed);
          if (got.consumed !== want.consumed)
            report_mismatch("nonce_consumed", want.consumed, got.consumed);
          if (got.pointer !== want.pointer)
            report_mismatch("register_pointer", want.pointer, got.pointer);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0]  vals [4];
    logic [3:0]  host_ops [5];
    int unsigned phase;
    int unsigned phase_end;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    int unsigned i;

    host_ops = '{OP_LOAD_NONCE, OP_LOAD_CONFIG, OP_READ_RX, OP_READ_ARMED, OP_CLEAR_FLAGS};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset register map. A NACK on the first
    // transmit slot is ignored, the status byte is sent once and then padded.
    send(OP_TX_SLOT, 8'h00, 1'b1, 5'd0, 8'h00);
    send(OP_ADDR_READ, 8'h00, 1'b0, 5'd0, 8'hFF);
    send(OP_TX_SLOT, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_TX_SLOT, 8'hFF, 1'b0, 5'd31, 8'h00);
    send(OP_TX_SLOT, 8'h00, 1'b1, 5'd0, 8'h00);
    send(OP_STOP, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_ADDR_WRITE, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_RX_BYTE, CommandRegReset, 1'b0, 5'd0, 8'h00);
    send(OP_RX_BYTE, 8'hFF, 1'b1, 5'd31, 8'hFF);
    send(OP_RX_BYTE, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_STOP, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_LOAD_NONCE, 8'hA5, 1'b0, 5'd0, 8'h00);
    send(OP_LOAD_NONCE, 8'h5A, 1'b0, 5'd15, 8'h00);
    send(OP_LOAD_NONCE, 8'hFF, 1'b0, 5'd31, 8'h00);
    send(OP_LOAD_CONFIG, 8'hFF, 1'b0, 5'd0, 8'h00);
    send(OP_LOAD_CONFIG, 8'h11, 1'b0, 5'd16, 8'h00);
    send(OP_ADDR_WRITE, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_RX_BYTE, NonceRegReset, 1'b0, 5'd0, 8'h00);
    send(OP_ADDR_READ, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_TX_SLOT, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_STOP, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_READ_ARMED, 8'h00, 1'b0, 5'd15, 8'h00);
    send(OP_READ_ARMED, 8'h00, 1'b0, 5'd31, 8'h00);
    send(OP_READ_RX, 8'h00, 1'b0, 5'd1, 8'h00);
    send(OP_BUS_ERROR, 8'h00, 1'b0, 5'd0, 8'h00);
    send(OP_CLEAR_FLAGS, 8'h00, 1'b0, 5'd0, 8'h00);
    send(4'd15, 8'hFF, 1'b1, 5'd31, 8'hFF);

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      if (phase > 0) begin
        case (phase)
          1: vals = '{8'hFF, 8'hFE, 8'hFD, 8'h00};
          2: vals = '{8'h00, 8'h00, 8'h00, 8'h00};
          3: vals = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
          4: vals = '{8'h07, 8'h03, 8'h05, 8'h05};
          default: begin
            for (i = 0; i < 4; i++) vals[i] = 8'($urandom_range(0, 7));
          end
        endcase
        write_register(CFG_STATUS, vals[0]);
        write_register(CFG_NONCE, vals[1]);
        write_register(CFG_CONFIG, vals[2]);
        write_register(CFG_COMMAND, vals[3]);
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
        @(negedge clk_i);
      end
      phase_end = stim_items + PhaseItems;
      while (stim_items < phase_end) begin
        if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
        r = $urandom_range(0, 99);
        if (r < 40) begin
          // Write transaction; leaving out the address phase now and then
          // turns the pointer byte into data.
          if ($urandom_range(0, 7) != 0) send_random(OP_ADDR_WRITE);
          send(OP_RX_BYTE, pick_pointer(), 1'($urandom), 5'($urandom), 8'($urandom));
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 5);
          for (i = 0; i < n; i++) send_random(OP_RX_BYTE);
          k = $urandom_range(0, 19);
          if (k < 17) send_random(OP_STOP);
          else if (k < 19) send_random(OP_BUS_ERROR);
        end else if (r < 65) begin
          if ($urandom_range(0, 1) == 1) begin
            send_random(OP_ADDR_WRITE);
            send(OP_RX_BYTE, pick_pointer(), 1'($urandom), 5'($urandom), 8'($urandom));
            send_random(OP_STOP);
          end
          send_random(OP_ADDR_READ);
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            send(OP_TX_SLOT, 8'($urandom),
                 (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0),
                 5'($urandom), 8'($urandom));
          end
          send(OP_TX_SLOT, 8'($urandom), 1'b1, 5'($urandom), 8'($urandom));
          if ($urandom_range(0, 4) != 0) send_random(OP_STOP);
        end else if (r < 90) begin
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 15);
          send(host_ops[$urandom_range(0, 4)], 8'($urandom), 1'($urandom), 5'(k),
               8'($urandom));
        end else begin
          send_random(4'($urandom_range(0, 15)));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
